// ===== rtl/bsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types, codes and sizes of the byte SIMD register machine.
// ----------------------------------------------------------------------------
package bsrm_pkg;

   localparam int NUM_REGS_DEF = 8;
   localparam int LANES_DEF    = 16;

   localparam int TAB_DEPTH = 65536;
   localparam int TAB_AW    = 16;

   localparam int ROW_IW  = 8;
   localparam int LANE_IW = 5;
   localparam int Q_DEPTH = 4;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_CONST_LIMIT = 1'b0;
   localparam logic [7:0] CONST_LIMIT_RST = 8'd127;

   localparam logic [1:0] REQ_EXEC  = 2'd0;
   localparam logic [1:0] REQ_WREG  = 2'd1;
   localparam logic [1:0] REQ_RREG  = 2'd2;
   localparam logic [1:0] REQ_WTAB  = 2'd3;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [2:0] K_ALU  = 3'd0;
   localparam logic [2:0] K_DIV  = 3'd1;
   localparam logic [2:0] K_WREG = 3'd2;
   localparam logic [2:0] K_RREG = 3'd3;
   localparam logic [2:0] K_WTAB = 3'd4;
   localparam logic [2:0] K_ERR  = 3'd5;

   typedef struct packed {
      logic [2:0]         kind;
      logic [ROW_IW-1:0]  dst;
      logic [ROW_IW-1:0]  src;
      logic [ROW_IW-1:0]  brow;
      logic               use_reg;
      logic [7:0]         imm;
      logic [1:0]         op;
      logic [LANE_IW-1:0] lane;
      logic [7:0]         data;
      logic [TAB_AW-1:0]  tix;
      logic               eop;
   } cmd_type;

endpackage

// ===== rtl/bsrm_front.sv =====
// ----------------------------------------------------------------------------
// bsrm_front
// Control register port, request intake and classification into commands.
// ----------------------------------------------------------------------------
module bsrm_front #(
   parameter int NUM_REGS = bsrm_pkg::NUM_REGS_DEF,
   parameter int LANES    = bsrm_pkg::LANES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bsrm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bsrm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bsrm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [2:0]                  req_dest_reg,
   input  logic [2:0]                  req_src_reg,
   input  logic [1:0]                  req_opcode,
   input  logic [8:0]                  req_arg_code,
   input  logic [3:0]                  req_lane,
   input  logic [7:0]                  req_data,
   input  logic [15:0]                 req_table_index,
   input  logic                        req_end_of_program,
   input  logic                        q_full,
   output logic                        q_push,
   output bsrm_pkg::cmd_type           q_cmd
);
   import bsrm_pkg::*;

   localparam logic [8:0] NR9 = 9'(NUM_REGS);
   localparam logic [5:0] NL6 = 6'(LANES);

   logic [7:0] const_limit_ff;
   logic [7:0] const_limit_in;
   logic       use_reg;
   logic [8:0] areg9;
   logic       dst_bad;
   logic       src_bad;
   logic       arg_bad;
   logic       lane_bad;

   assign csr_pready = 1'b1;

   always_comb begin
      const_limit_in = const_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_CONST_LIMIT) begin
         const_limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         const_limit_ff <= CONST_LIMIT_RST;
      end else begin
         const_limit_ff <= const_limit_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_CONST_LIMIT) ?
                       {{(CSR_DW-8){1'b0}}, const_limit_ff} : '0;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign use_reg  = req_arg_code > {1'b0, const_limit_ff};
   assign areg9    = req_arg_code - {1'b0, const_limit_ff} - 9'd1;
   assign dst_bad  = {6'd0, req_dest_reg} >= NR9;
   assign src_bad  = {6'd0, req_src_reg} >= NR9;
   assign arg_bad  = use_reg && (areg9 >= NR9);
   assign lane_bad = {2'd0, req_lane} >= NL6;

   always_comb begin
      q_cmd         = '0;
      q_cmd.dst     = ROW_IW'({6'd0, req_dest_reg});
      q_cmd.src     = ROW_IW'({6'd0, req_src_reg});
      q_cmd.brow    = use_reg ? areg9[ROW_IW-1:0] : '0;
      q_cmd.use_reg = use_reg;
      q_cmd.imm     = req_arg_code[7:0];
      q_cmd.op      = req_opcode;
      q_cmd.lane    = LANE_IW'({1'b0, req_lane});
      q_cmd.data    = req_data;
      q_cmd.tix     = req_table_index;
      unique case (req_type)
         REQ_EXEC: begin
            q_cmd.eop = req_end_of_program;
            if (dst_bad || src_bad || arg_bad) begin
               q_cmd.kind = K_ERR;
            end else if (req_opcode == OP_DIV) begin
               q_cmd.kind = K_DIV;
            end else begin
               q_cmd.kind = K_ALU;
            end
         end
         REQ_WREG: begin
            q_cmd.kind = (dst_bad || lane_bad) ? K_ERR : K_WREG;
         end
         REQ_RREG: begin
            q_cmd.kind = (src_bad || lane_bad) ? K_ERR : K_RREG;
         end
         default: begin
            q_cmd.kind = K_WTAB;
         end
      endcase
   end

endmodule

// ===== rtl/bsrm_queue.sv =====
// ----------------------------------------------------------------------------
// bsrm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bsrm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsrm_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output bsrm_pkg::cmd_type head_cmd
);
   import bsrm_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);
   localparam int CW = $clog2(Q_DEPTH + 1);

   cmd_type         slot_ff [Q_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = count_ff == CW'(Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bsrm_back.sv =====
// ----------------------------------------------------------------------------
// bsrm_back
// Command sequencer: lane register file, division table, result register.
// ----------------------------------------------------------------------------
module bsrm_back #(
   parameter int NUM_REGS = bsrm_pkg::NUM_REGS_DEF,
   parameter int LANES    = bsrm_pkg::LANES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bsrm_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_status,
   output logic              rsp_program_done
);
   import bsrm_pkg::*;

   localparam int RW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CW    = $clog2(LANES + 1);
   localparam int ROWW  = LANES * 8;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_DWR  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [ROWW-1:0]   rf_mem [NUM_REGS];
   logic [7:0]        tab_mem [TAB_DEPTH];

   logic [2:0]        state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [NUM_REGS-1:0] row_valid_ff, row_valid_in;
   logic [ROWW-1:0]   rqa_ff, rqb_ff;
   logic              va_ff, vb_ff;
   logic [ROWW-1:0]   opa_ff, opa_in;
   logic [ROWW-1:0]   opb_ff, opb_in;
   logic [ROWW-1:0]   res_ff, res_in;
   logic [7:0]        rdat_ff, rdat_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              capv_ff, capv_in;
   logic [LW-1:0]     capl_ff, capl_in;
   logic [7:0]        tab_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_read_data_ff, rsp_read_data_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              rf_re, rf_we;
   logic [RW-1:0]     ra_addr, rb_addr, wa_addr;
   logic [ROWW-1:0]   wd_row;
   logic              tab_we, tab_re;
   logic [TAB_AW-1:0] tab_raddr;
   logic [ROWW-1:0]   a_row, b_row, alu_row, wreg_row;
   logic [LW-1:0]     cur_lane, cnt_lane;

   assign cur_lane = cur_ff.lane[LW-1:0];
   assign cnt_lane = cnt_ff[LW-1:0];
   assign a_row    = va_ff ? rqa_ff : '0;
   assign b_row    = cur_ff.use_reg ? (vb_ff ? rqb_ff : '0) : {LANES{cur_ff.imm}};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         case (cur_ff.op)
            OP_ADD:  alu_row[l*8 +: 8] = a_row[l*8 +: 8] + b_row[l*8 +: 8];
            OP_SUB:  alu_row[l*8 +: 8] = a_row[l*8 +: 8] - b_row[l*8 +: 8];
            OP_MUL:  alu_row[l*8 +: 8] = a_row[l*8 +: 8] * b_row[l*8 +: 8];
            default: alu_row[l*8 +: 8] = '0;
         endcase
      end
   end

   always_comb begin
      wreg_row = a_row;
      wreg_row[cur_lane*8 +: 8] = cur_ff.data;
   end

   always_comb begin
      state_in         = state_ff;
      cur_in           = cur_ff;
      row_valid_in     = row_valid_ff;
      opa_in           = opa_ff;
      opb_in           = opb_ff;
      res_in           = res_ff;
      rdat_in          = rdat_ff;
      cnt_in           = cnt_ff;
      capv_in          = 1'b0;
      capl_in          = capl_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_done_in      = rsp_done_ff;
      cmd_pop          = 1'b0;
      rf_re            = 1'b0;
      rf_we            = 1'b0;
      ra_addr          = (cmd.kind == K_WREG) ? cmd.dst[RW-1:0] : cmd.src[RW-1:0];
      rb_addr          = cmd.brow[RW-1:0];
      wa_addr          = cur_ff.dst[RW-1:0];
      wd_row           = alu_row;
      tab_we           = 1'b0;
      tab_re           = 1'b0;
      tab_raddr        = {opa_ff[cnt_lane*8 +: 8], opb_ff[cnt_lane*8 +: 8]};

      if (capv_ff) begin
         res_in[capl_ff*8 +: 8] = tab_q_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               rf_re   = 1'b1;
               if (cmd.kind == K_WTAB) begin
                  tab_we   = 1'b1;
                  state_in = S_RESP;
               end else if (cmd.kind == K_ERR) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (cur_ff.kind)
               K_ALU: begin
                  rf_we = 1'b1;
                  row_valid_in[wa_addr] = 1'b1;
               end
               K_WREG: begin
                  rf_we  = 1'b1;
                  wd_row = wreg_row;
                  row_valid_in[wa_addr] = 1'b1;
               end
               K_RREG: begin
                  rdat_in = a_row[cur_lane*8 +: 8];
               end
               K_DIV: begin
                  opa_in   = a_row;
                  opb_in   = b_row;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            if (cnt_ff < CW'(LANES)) begin
               tab_re  = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               capv_in = 1'b1;
               capl_in = cnt_lane;
            end else if (!capv_ff) begin
               state_in = S_DWR;
            end
         end
         S_DWR: begin
            rf_we    = 1'b1;
            wd_row   = res_ff;
            row_valid_in[wa_addr] = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = (cur_ff.kind == K_RREG) ? rdat_ff : '0;
               rsp_status_in    = cur_ff.kind == K_ERR;
               rsp_done_in      = cur_ff.eop;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         capv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         capv_ff      <= capv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      opa_ff           <= opa_in;
      opb_ff           <= opb_in;
      res_ff           <= res_in;
      rdat_ff          <= rdat_in;
      cnt_ff           <= cnt_in;
      capl_ff          <= capl_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_done_ff      <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[wa_addr] <= wd_row;
      end
      if (rf_re) begin
         rqa_ff <= rf_mem[ra_addr];
         rqb_ff <= rf_mem[rb_addr];
         va_ff  <= row_valid_ff[ra_addr];
         vb_ff  <= row_valid_ff[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[cmd.tix] <= cmd.data;
      end
      if (tab_re) begin
         tab_q_ff <= tab_mem[tab_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_program_done = rsp_done_ff;

endmodule

// ===== rtl/byte_simd_register_machine_top.sv =====
// ----------------------------------------------------------------------------
// byte_simd_register_machine_top
// Runs byte instructions on LANES lanes, each with its own byte of every register.
// ----------------------------------------------------------------------------
// Requests enter on the req_ valid/ready channel; each gives exactly one item
// on the rsp_ channel, in order. The csr_ APB port holds const_limit at
// address 0, which must be written only while the block is idle; the block
// itself does not enforce this. A front stage decodes the operand against
// const_limit, checks register and lane indexes and queues a command (four
// deep); the back sequencer then runs it.
// Back states: a table write or bad index goes from idle to the response;
// register read, register write, add, subtract and multiply pass through the
// execute state; divide adds lookup and row write states, the lookup paced by
// the one read port of the division table that serves one lane per cycle.
// req_ready stays high while the queue has room, so items are taken while
// earlier ones run and while a result waits on rsp_ready.
// Reset clears the queue, the response valid flag, the register file (by row
// valid bits) and sets const_limit to 127; the division table keeps
// whatever it holds until written.
// ----------------------------------------------------------------------------
module byte_simd_register_machine_top #(
   parameter int NUM_REGS = bsrm_pkg::NUM_REGS_DEF,
   parameter int LANES    = bsrm_pkg::LANES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bsrm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [bsrm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [bsrm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [2:0]                  req_dest_reg,
   input  logic [2:0]                  req_src_reg,
   input  logic [1:0]                  req_opcode,
   input  logic [8:0]                  req_arg_code,
   input  logic [3:0]                  req_lane,
   input  logic [7:0]                  req_data,
   input  logic [15:0]                 req_table_index,
   input  logic                        req_end_of_program,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_read_data,
   output logic                        rsp_status,
   output logic                        rsp_program_done
);
   import bsrm_pkg::*;

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    cmd_pop;

   bsrm_front #(
      .NUM_REGS(NUM_REGS),
      .LANES(LANES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_dest_reg(req_dest_reg),
      .req_src_reg(req_src_reg),
      .req_opcode(req_opcode),
      .req_arg_code(req_arg_code),
      .req_lane(req_lane),
      .req_data(req_data),
      .req_table_index(req_table_index),
      .req_end_of_program(req_end_of_program),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(q_cmd)
   );

   bsrm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(q_cmd),
      .pop(cmd_pop),
      .full(q_full),
      .head_valid(head_valid),
      .head_cmd(head_cmd)
   );

   bsrm_back #(
      .NUM_REGS(NUM_REGS),
      .LANES(LANES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(head_valid),
      .cmd(head_cmd),
      .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status),
      .rsp_program_done(rsp_program_done)
   );

endmodule

// ===== bench/tb_byte_simd_register_machine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_simd_register_machine_top
// Self-checking bench for the byte SIMD register machine.
// ----------------------------------------------------------------------------
// Short directed tests cover register load/read, each operation, wrap-around,
// operand decode at const_limit 0, 127 and 255, a bad operand register and a
// destination equal to a source. Random programs follow: register loads, an
// instruction run closed by end_of_program and read-back, mixed with noise.
// Each phase runs at its own const_limit. A shadow copy of the register file
// and the division table predicts every item; divide table entries that a
// divide will read are loaded first. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_byte_simd_register_machine_top;
   import bsrm_pkg::*;

   localparam int NUM_REGS = NUM_REGS_DEF;
   localparam int LANES    = LANES_DEF;
   localparam logic [CSR_AW-1:0] LIMIT_ADDR = {CSR_CONST_LIMIT, 2'b00};

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  dst;
      logic [2:0]  src;
      logic [1:0]  opcode;
      logic [8:0]  arg;
      logic [3:0]  lane;
      logic [7:0]  data;
      logic [15:0] tix;
      logic        eop;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
      logic       done;
   } rsp_item_type;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_type;
   logic [2:0]        req_dest_reg;
   logic [2:0]        req_src_reg;
   logic [1:0]        req_opcode;
   logic [8:0]        req_arg_code;
   logic [3:0]        req_lane;
   logic [7:0]        req_data;
   logic [15:0]       req_table_index;
   logic              req_end_of_program;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_read_data;
   logic              rsp_status;
   logic              rsp_program_done;

   logic [7:0]   reg_bank [NUM_REGS][LANES];
   logic [7:0]   div_table [TAB_DEPTH];
   bit           table_loaded [TAB_DEPTH];
   logic [7:0]   imm_ceiling = CONST_LIMIT_RST;
   rsp_item_type pending_replies [$];
   int           mismatches = 0;
   int           issued = 0;
   bit           steady = 1'b0;
   bit           rsp_taken = 1'b0;
   int           stall_left = 0;

   byte_simd_register_machine_top #(
      .NUM_REGS(NUM_REGS),
      .LANES(LANES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_dest_reg(req_dest_reg),
      .req_src_reg(req_src_reg),
      .req_opcode(req_opcode),
      .req_arg_code(req_arg_code),
      .req_lane(req_lane),
      .req_data(req_data),
      .req_table_index(req_table_index),
      .req_end_of_program(req_end_of_program),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status),
      .rsp_program_done(rsp_program_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_byte_simd_register_machine_top: done, errors");
      $finish;
   end

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic bit exec_ok(input req_item_type r);
      int areg;
      areg = int'(r.arg) - int'(imm_ceiling) - 1;
      return int'(r.dst) < NUM_REGS && int'(r.src) < NUM_REGS && areg < NUM_REGS;
   endfunction

   function automatic logic [7:0] operand_b(input req_item_type r, input int l);
      if (int'(r.arg) <= int'(imm_ceiling)) begin
         return r.arg[7:0];
      end
      return reg_bank[int'(r.arg) - int'(imm_ceiling) - 1][l];
   endfunction

   function automatic rsp_item_type apply_request(input req_item_type r);
      rsp_item_type o;
      logic [7:0]   res [LANES];
      logic [7:0]   a;
      logic [7:0]   b;
      o = '0;
      case (r.kind)
         REQ_EXEC: begin
            o.done = r.eop;
            if (!exec_ok(r)) begin
               o.status = 1'b1;
            end else begin
               for (int l = 0; l < LANES; l++) begin
                  a = reg_bank[r.src][l];
                  b = operand_b(r, l);
                  case (r.opcode)
                     OP_ADD:  res[l] = a + b;
                     OP_SUB:  res[l] = a - b;
                     OP_MUL:  res[l] = a * b;
                     default: res[l] = div_table[{a, b}];
                  endcase
               end
               for (int l = 0; l < LANES; l++) begin
                  reg_bank[r.dst][l] = res[l];
               end
            end
         end
         REQ_WREG: begin
            if (int'(r.dst) >= NUM_REGS || int'(r.lane) >= LANES) begin
               o.status = 1'b1;
            end else begin
               reg_bank[r.dst][r.lane] = r.data;
            end
         end
         REQ_RREG: begin
            if (int'(r.src) >= NUM_REGS || int'(r.lane) >= LANES) begin
               o.status = 1'b1;
            end else begin
               o.read_data = reg_bank[r.src][r.lane];
            end
         end
         default: begin
            div_table[r.tix] = r.data;
            table_loaded[r.tix] = 1'b1;
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------- item builders
   function automatic req_item_type random_req();
      req_item_type r;
      r.kind   = 2'($urandom);
      r.dst    = 3'($urandom);
      r.src    = 3'($urandom);
      r.opcode = 2'($urandom);
      r.arg    = 9'($urandom);
      r.lane   = 4'($urandom);
      r.data   = 8'($urandom);
      r.tix    = 16'($urandom);
      r.eop    = 1'($urandom);
      return r;
   endfunction

   function automatic req_item_type exec_req(input int dst, src, op, arg, input bit eop);
      req_item_type r;
      r = random_req();
      r.kind   = REQ_EXEC;
      r.dst    = 3'(dst);
      r.src    = 3'(src);
      r.opcode = 2'(op);
      r.arg    = 9'(arg);
      r.eop    = eop;
      return r;
   endfunction

   function automatic req_item_type reg_req(input logic [1:0] kind, input int regno, lane,
                                            data);
      req_item_type r;
      r = random_req();
      r.kind = kind;
      if (kind == REQ_WREG) begin
         r.dst = 3'(regno);
      end else begin
         r.src = 3'(regno);
      end
      r.lane = 4'(lane);
      r.data = 8'(data);
      return r;
   endfunction

   // constant 45%, register 45%, out-of-range register 10%
   function automatic logic [8:0] pick_arg();
      int roll;
      int lim;
      roll = $urandom_range(19);
      lim  = int'(imm_ceiling);
      if (roll < 9) begin
         return 9'($urandom_range(lim, 0));
      end
      if (roll < 18) begin
         return 9'(lim + 1 + $urandom_range(NUM_REGS - 1));
      end
      return 9'($urandom_range(511, lim + 1 + NUM_REGS));
   endfunction

   // ------------------------------------------------------------------ drivers
   task automatic send_req(input req_item_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(8);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_type           = r.kind;
      req_dest_reg       = r.dst;
      req_src_reg        = r.src;
      req_opcode         = r.opcode;
      req_arg_code       = r.arg;
      req_lane           = r.lane;
      req_data           = r.data;
      req_table_index    = r.tix;
      req_end_of_program = r.eop;
      do @(posedge clock); while (!req_ready);
      pending_replies.push_back(apply_request(r));
      issued++;
   endtask

   // a divide only reads table entries that were loaded beforehand
   task automatic run_req(input req_item_type r);
      req_item_type fill;
      logic [15:0]  ix;
      if (r.kind == REQ_EXEC && r.opcode == OP_DIV && exec_ok(r)) begin
         for (int l = 0; l < LANES; l++) begin
            ix = {reg_bank[r.src][l], operand_b(r, l)};
            if (!table_loaded[ix]) begin
               fill      = random_req();
               fill.kind = REQ_WTAB;
               fill.tix  = ix;
               send_req(fill);
            end
         end
      end
      send_req(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [7:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = LIMIT_ADDR;
      csr_pwdata  = CSR_DW'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         imm_ceiling = value;
      end else if (csr_prdata !== CSR_DW'(imm_ceiling)) begin
         note_mismatch("const_limit readback", CSR_DW'(imm_ceiling), csr_prdata);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_limit(input logic [7:0] value);
      wait_idle();
      csr_access(1'b1, value);
      csr_access(1'b0, 8'd0);
   endtask

   // ------------------------------------------------------------------ checker
   always @(posedge clock) begin : reply_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (pending_replies.size() == 0) begin
            note_mismatch("item with none expected", 32'd0, 32'd1);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_read_data !== want.read_data) begin
               note_mismatch("read_data", 32'(want.read_data), 32'(rsp_read_data));
            end
            if (rsp_status !== want.status) begin
               note_mismatch("status", 32'(want.status), 32'(rsp_status));
            end
            if (rsp_program_done !== want.done) begin
               note_mismatch("program_done", 32'(want.done), 32'(rsp_program_done));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken  = 1'b0;
         stall_left = steady ? 0 : $urandom_range(8);
      end
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // -------------------------------------------------------------------- tests
   task automatic test_reset_state();
      csr_access(1'b0, 8'd0);
      run_req(reg_req(REQ_RREG, 0, 0, 0));
      run_req(reg_req(REQ_RREG, NUM_REGS - 1, LANES - 1, 0));
   endtask

   task automatic test_register_port();
      run_req(reg_req(REQ_WREG, NUM_REGS - 1, LANES - 1, 255));
      run_req(reg_req(REQ_WREG, 0, 0, 128));
      run_req(reg_req(REQ_RREG, NUM_REGS - 1, LANES - 1, 0));
      run_req(reg_req(REQ_RREG, 0, 0, 0));
   endtask

   // const_limit is 127 here: codes 128..135 are r0..r7
   task automatic test_operations();
      steady = 1'b1;
      run_req(exec_req(2, 7, OP_ADD, 1, 1'b0));
      run_req(exec_req(3, 0, OP_SUB, 127, 1'b0));
      run_req(exec_req(4, 7, OP_MUL, 135, 1'b0));
      run_req(exec_req(5, 4, OP_DIV, 131, 1'b0));
      run_req(exec_req(7, 7, OP_ADD, 135, 1'b1));
      run_req(exec_req(1, 2, OP_MUL, 136, 1'b1));
      run_req(exec_req(1, 2, OP_SUB, 511, 1'b0));
      steady = 1'b0;
      run_req(reg_req(REQ_RREG, 2, 15, 0));
      run_req(reg_req(REQ_RREG, 3, 0, 0));
      run_req(reg_req(REQ_RREG, 4, 15, 0));
      run_req(reg_req(REQ_RREG, 5, 3, 0));
      run_req(reg_req(REQ_RREG, 7, 15, 0));
   endtask

   task automatic test_limit_extremes();
      set_limit(8'd0);
      run_req(exec_req(1, 3, OP_ADD, 0, 1'b0));
      run_req(exec_req(2, 1, OP_SUB, 1, 1'b0));
      run_req(exec_req(6, 3, OP_MUL, 8, 1'b0));
      run_req(exec_req(6, 3, OP_ADD, 9, 1'b1));
      run_req(reg_req(REQ_RREG, 2, 9, 0));
      set_limit(8'd255);
      run_req(exec_req(1, 3, OP_ADD, 255, 1'b0));
      run_req(exec_req(2, 1, OP_DIV, 263, 1'b0));
      run_req(exec_req(6, 2, OP_MUL, 256, 1'b0));
      run_req(exec_req(6, 2, OP_SUB, 264, 1'b1));
      run_req(reg_req(REQ_RREG, 6, 0, 0));
   endtask

   task automatic run_program();
      int           loads;
      int           ops;
      int           reads;
      int           last_dst;
      int           op;
      bit           broken;
      req_item_type r;
      loads  = $urandom_range(6, 1);
      ops    = $urandom_range(8, 2);
      reads  = $urandom_range(4, 1);
      broken = ($urandom_range(9) == 0);
      last_dst = 0;
      repeat (loads) begin
         run_req(reg_req(REQ_WREG, $urandom_range(7), $urandom_range(15), $urandom_range(255)));
      end
      for (int i = 0; i < ops; i++) begin
         op = ($urandom_range(7) == 0) ? int'(OP_DIV) : $urandom_range(2);
         r  = exec_req($urandom_range(7), $urandom_range(7), op, pick_arg(),
                       broken ? 1'($urandom) : (i == ops - 1));
         last_dst = int'(r.dst);
         run_req(r);
      end
      repeat (reads) begin
         run_req(reg_req(REQ_RREG, $urandom_range(1) ? last_dst : $urandom_range(7),
                         $urandom_range(15), 0));
      end
   endtask

   task automatic test_random_programs();
      logic [7:0] limits [6];
      int         quota;
      limits = '{8'd127, 8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'd127};
      foreach (limits[p]) begin
         set_limit(limits[p]);
         quota = issued + 185;
         while (issued < quota) begin
            steady = ($urandom_range(3) == 0);
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(3, 1)) run_req(random_req());
            end else begin
               run_program();
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_valid          = 1'b0;
      req_type           = REQ_EXEC;
      req_dest_reg       = '0;
      req_src_reg        = '0;
      req_opcode         = OP_ADD;
      req_arg_code       = '0;
      req_lane           = '0;
      req_data           = '0;
      req_table_index    = '0;
      req_end_of_program = 1'b0;
      foreach (reg_bank[r, l]) reg_bank[r][l] = 8'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_register_port();
      test_operations();
      test_limit_extremes();
      test_random_programs();

      wait_idle();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_byte_simd_register_machine_top: done, clean");
      end else begin
         $display("tb_byte_simd_register_machine_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bsrm_pkg.sv
rtl/bsrm_front.sv
rtl/bsrm_queue.sv
rtl/bsrm_back.sv
rtl/byte_simd_register_machine_top.sv
bench/tb_byte_simd_register_machine_top.sv
